// ----- hdl/ace_pkg.sv -----
// Shared types and constants for the ANSI color escape encoder.
`timescale 1ns / 1ps
`default_nettype none
package ace_pkg;

	// Item kinds
	localparam logic [1:0] KIND_SET     = 2'd0;
	localparam logic [1:0] KIND_DATA    = 2'd1;
	localparam logic [1:0] KIND_RESTORE = 2'd2;

	// Attribute byte layout: bold[7], inverse[6], bg[5:3], fg[2:0]
	typedef struct packed {
		logic       bold;
		logic       inverse;
		logic [2:0] bg;
		logic [2:0] fg;
	} attr_t;

	localparam attr_t ATTR_DEFAULT = '{bold: 1'b0, inverse: 1'b0, bg: 3'd0, fg: 3'd7};

	// Byte slots of one output run, in emission order
	localparam int NUM_SLOTS = 15;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);

	localparam logic [SLOT_W-1:0] SLOT_ESC      = 4'd0;
	localparam logic [SLOT_W-1:0] SLOT_BRACKET  = 4'd1;
	localparam logic [SLOT_W-1:0] SLOT_BG_LEAD  = 4'd2;
	localparam logic [SLOT_W-1:0] SLOT_BG_DIGIT = 4'd3;
	localparam logic [SLOT_W-1:0] SLOT_FG_SEP   = 4'd4;
	localparam logic [SLOT_W-1:0] SLOT_FG_LEAD  = 4'd5;
	localparam logic [SLOT_W-1:0] SLOT_FG_DIGIT = 4'd6;
	localparam logic [SLOT_W-1:0] SLOT_INV_SEP  = 4'd7;
	localparam logic [SLOT_W-1:0] SLOT_INV_OFF  = 4'd8;
	localparam logic [SLOT_W-1:0] SLOT_INV_7    = 4'd9;
	localparam logic [SLOT_W-1:0] SLOT_BLD_SEP  = 4'd10;
	localparam logic [SLOT_W-1:0] SLOT_BLD_HEAD = 4'd11;
	localparam logic [SLOT_W-1:0] SLOT_BLD_OFF  = 4'd12;
	localparam logic [SLOT_W-1:0] SLOT_FINAL_M  = 4'd13;
	localparam logic [SLOT_W-1:0] SLOT_DATA     = 4'd14;

	// Character codes
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_M     = 8'h6D;

	// Input transaction
	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] fg_color;
		logic [2:0] bg_color;
		logic       inverse_on;
		logic       bold_on;
		logic [7:0] data_byte;
	} in_item_t;

	// Output transaction
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	// Classified command handed from front to back
	typedef struct packed {
		logic [NUM_SLOTS-1:0] slots;
		attr_t                attrs;
		logic [7:0]           data_byte;
	} cmd_t;

endpackage
`default_nettype wire

// ----- hdl/ace_front.sv -----
// Front end: accepts transactions, tracks attributes and classifies each run into slot masks.
`timescale 1ns / 1ps
`default_nettype none
module ace_front
	import ace_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	output logic          item_ready,
	input  wire in_item_t item,
	input  wire logic     q_full,
	output logic          q_push,
	output cmd_t          q_cmd
);

	attr_t requested_q;
	attr_t written_q;
	logic  ever_q;

	attr_t a;
	logic  do_bg, do_fg, do_inv, do_bold, any_code;
	logic  take, is_data, is_restore;

	assign item_ready = !q_full;
	assign take       = item_valid && item_ready;
	assign is_data    = (item.kind == KIND_DATA);
	assign is_restore = (item.kind == KIND_RESTORE);

	// Attributes this run must reach, and which codes changed
	always_comb begin
		a        = is_restore ? ATTR_DEFAULT : requested_q;
		do_bg    = !ever_q || (a.bg != written_q.bg);
		do_fg    = !ever_q || (a.fg != written_q.fg);
		do_inv   = !ever_q || (a.inverse != written_q.inverse);
		do_bold  = !ever_q || (a.bold != written_q.bold);
		any_code = do_bg || do_fg || do_inv || do_bold;
	end

	// Slot mask of the run
	always_comb begin
		q_cmd.slots                = '0;
		q_cmd.slots[SLOT_ESC]      = any_code;
		q_cmd.slots[SLOT_BRACKET]  = any_code;
		q_cmd.slots[SLOT_BG_LEAD]  = do_bg;
		q_cmd.slots[SLOT_BG_DIGIT] = do_bg;
		q_cmd.slots[SLOT_FG_SEP]   = do_fg && do_bg;
		q_cmd.slots[SLOT_FG_LEAD]  = do_fg;
		q_cmd.slots[SLOT_FG_DIGIT] = do_fg;
		q_cmd.slots[SLOT_INV_SEP]  = do_inv && (do_bg || do_fg);
		q_cmd.slots[SLOT_INV_OFF]  = do_inv && !a.inverse;
		q_cmd.slots[SLOT_INV_7]    = do_inv;
		q_cmd.slots[SLOT_BLD_SEP]  = do_bold && (do_bg || do_fg || do_inv);
		q_cmd.slots[SLOT_BLD_HEAD] = do_bold;
		q_cmd.slots[SLOT_BLD_OFF]  = do_bold && !a.bold;
		q_cmd.slots[SLOT_FINAL_M]  = any_code;
		q_cmd.slots[SLOT_DATA]     = is_data;
		q_cmd.attrs                = a;
		q_cmd.data_byte            = item.data_byte;
	end

	// A restore with nothing changed yields no run
	assign q_push = take && (is_data || (is_restore && any_code));

	// Attribute state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			requested_q <= ATTR_DEFAULT;
			written_q   <= ATTR_DEFAULT;
			ever_q      <= 1'b0;
		end else if (take) begin
			case (item.kind)
				KIND_SET: begin
					requested_q <= '{bold: item.bold_on, inverse: item.inverse_on,
						bg: item.bg_color, fg: item.fg_color};
				end
				KIND_DATA: begin
					written_q <= a;
					ever_q    <= 1'b1;
				end
				KIND_RESTORE: begin
					requested_q <= ATTR_DEFAULT;
					written_q   <= a;
					ever_q      <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/ace_queue.sv -----
// Small command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module ace_queue
	import ace_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output logic      full,
	output logic      not_empty,
	output cmd_t      head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/ace_back.sv -----
// Back end: walks the slot mask of the head command and drives the output register.
`timescale 1ns / 1ps
`default_nettype none
module ace_back
	import ace_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_not_empty,
	input  wire cmd_t  q_head,
	output logic       q_pop,
	output logic       res_valid,
	input  wire logic  res_ready,
	output out_item_t  res
);

	logic [NUM_SLOTS-1:0] done_q;
	logic [NUM_SLOTS-1:0] remaining;
	logic [NUM_SLOTS-1:0] pick_mask;
	logic [SLOT_W-1:0]    pick;
	logic                 emit, final_byte;
	logic [7:0]           byte_n;
	logic                 res_valid_q;
	out_item_t            res_q;

	assign remaining = q_head.slots & ~done_q;

	// Lowest pending slot
	always_comb begin
		pick = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (remaining[i]) begin
				pick = SLOT_W'(i);
			end
		end
	end

	assign pick_mask  = NUM_SLOTS'(1) << pick;
	assign final_byte = ((remaining & ~pick_mask) == '0);
	assign emit       = q_not_empty && (!res_valid_q || res_ready);
	assign q_pop      = emit && final_byte;

	// Byte for the chosen slot
	always_comb begin
		case (pick)
			SLOT_ESC:      byte_n = CH_ESC;
			SLOT_BRACKET:  byte_n = CH_LBRK;
			SLOT_BG_LEAD:  byte_n = CH_FOUR;
			SLOT_BG_DIGIT: byte_n = CH_ZERO | {5'd0, q_head.attrs.bg};
			SLOT_FG_SEP:   byte_n = CH_SEMI;
			SLOT_FG_LEAD:  byte_n = CH_THREE;
			SLOT_FG_DIGIT: byte_n = CH_ZERO | {5'd0, q_head.attrs.fg};
			SLOT_INV_SEP:  byte_n = CH_SEMI;
			SLOT_INV_OFF:  byte_n = CH_TWO;
			SLOT_INV_7:    byte_n = CH_SEVEN;
			SLOT_BLD_SEP:  byte_n = CH_SEMI;
			SLOT_BLD_HEAD: byte_n = q_head.attrs.bold ? CH_ONE : CH_TWO;
			SLOT_BLD_OFF:  byte_n = CH_TWO;
			SLOT_FINAL_M:  byte_n = CH_M;
			SLOT_DATA:     byte_n = q_head.data_byte;
			default:       byte_n = CH_ESC;
		endcase
	end

	// Progress through the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (emit) begin
			done_q <= final_byte ? '0 : (done_q | pick_mask);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= '{out_byte: byte_n, last: final_byte};
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

// ----- hdl/ansi_color_escape_encoder.sv -----
// Top level of the ANSI color escape encoder.
`timescale 1ns / 1ps
`default_nettype none
// Inserts ANSI SGR escape runs into a terminal byte stream. A set-color
// transaction records attributes and yields nothing; a data transaction yields
// ESC '[' plus the changed codes (background, foreground, inverse, bold) and 'm',
// followed by its byte marked last; a restore transaction yields the run alone.
// The front end takes one transaction per cycle while the command queue has
// room; the back end sends one output byte per cycle while a command waits
// and the output is ready. Plain text bytes with unchanged attributes pass at
// one per cycle while the output is ready. QUEUE_DEPTH sets how many
// classified runs can wait between the two ends.
module ansi_color_escape_encoder
	import ace_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_ready,
	input  wire in_item_t  item,
	output logic           res_valid,
	input  wire logic      res_ready,
	output out_item_t      res
);

	logic q_full, q_push, q_pop, q_not_empty;
	cmd_t q_cmd, q_head;

	ace_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	ace_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	ace_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

endmodule
`default_nettype wire

// ----- verif/ansi_color_escape_encoder_tb.sv -----
// Self-checking testbench for the ANSI color escape encoder.
`timescale 1ns / 1ps
module ansi_color_escape_encoder_tb;
	import ace_pkg::*;

	// Kind code that the encoder must drop
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int unsigned RANDOM_ITEMS = 350;
	localparam int unsigned MAX_REPORTS = 20;

	typedef struct {
		in_item_t         item;
		bit               known;  // bytes below are the literal expectation
		logic [14:0][7:0] bytes;  // emission order: bytes[count-1] first
		int unsigned      count;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_item_t  item;
	logic      res_valid;
	logic      res_ready;
	out_item_t res;

	// Attribute tracking for the SGR run predictor
	attr_t       req_attr;
	attr_t       shown_attr;
	bit          shown_once;
	logic [7:0]  run_bytes[$];
	out_item_t   sgr_expect_q[$];
	stim_row_t   stim_rows[$];
	bit          steady_run;
	int unsigned err_count;
	int unsigned rx_count;

	ansi_color_escape_encoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
	endtask

	function automatic in_item_t mk_item(input logic [1:0] kind, input logic [2:0] fg,
			input logic [2:0] bg, input logic inv, input logic bold, input logic [7:0] data);
		in_item_t it;
		it.kind       = kind;
		it.fg_color   = fg;
		it.bg_color   = bg;
		it.inverse_on = inv;
		it.bold_on    = bold;
		it.data_byte  = data;
		return it;
	endfunction

	task automatic add_row(input in_item_t it, input bit known, input logic [119:0] bytes,
			input int unsigned count);
		stim_row_t row;
		row.item  = it;
		row.known = known;
		row.bytes = bytes;
		row.count = count;
		stim_rows.push_back(row);
	endtask

	// Escape run for the pending attributes; only changed codes after the first run
	task automatic emit_sgr();
		attr_t diff;
		bit    do_bg, do_fg, do_inv, do_bold;
		bit    sep;
		diff    = req_attr ^ shown_attr;
		do_bg   = !shown_once || (diff.bg != 3'd0);
		do_fg   = !shown_once || (diff.fg != 3'd0);
		do_inv  = !shown_once || diff.inverse;
		do_bold = !shown_once || diff.bold;
		sep     = 1'b0;
		shown_once = 1'b1;
		shown_attr = req_attr;
		if (!(do_bg || do_fg || do_inv || do_bold)) begin
			return;
		end
		run_bytes.push_back(CH_ESC);
		run_bytes.push_back(CH_LBRK);
		if (do_bg) begin
			run_bytes.push_back(CH_FOUR);
			run_bytes.push_back(CH_ZERO + {5'd0, req_attr.bg});
			sep = 1'b1;
		end
		if (do_fg) begin
			if (sep) run_bytes.push_back(CH_SEMI);
			run_bytes.push_back(CH_THREE);
			run_bytes.push_back(CH_ZERO + {5'd0, req_attr.fg});
			sep = 1'b1;
		end
		if (do_inv) begin
			if (sep) run_bytes.push_back(CH_SEMI);
			if (!req_attr.inverse) run_bytes.push_back(CH_TWO);
			run_bytes.push_back(CH_SEVEN);
			sep = 1'b1;
		end
		if (do_bold) begin
			if (sep) run_bytes.push_back(CH_SEMI);
			if (req_attr.bold) begin
				run_bytes.push_back(CH_ONE);
			end else begin
				run_bytes.push_back(CH_TWO);
				run_bytes.push_back(CH_TWO);
			end
		end
		run_bytes.push_back(CH_M);
	endtask

	// Output bytes caused by one accepted transaction, left in run_bytes
	task automatic predict_sgr_run(input in_item_t it);
		run_bytes.delete();
		case (it.kind)
			KIND_SET: begin
				req_attr.fg      = it.fg_color;
				req_attr.bg      = it.bg_color;
				req_attr.inverse = it.inverse_on;
				req_attr.bold    = it.bold_on;
			end
			KIND_DATA: begin
				emit_sgr();
				run_bytes.push_back(it.data_byte);
			end
			KIND_RESTORE: begin
				req_attr = ATTR_DEFAULT;
				emit_sgr();
			end
			default: ;
		endcase
	endtask

	// Entered right after a falling edge; returns right after a falling edge, once the item is taken
	task automatic drive_row(input stim_row_t row);
		out_item_t e;
		while (!steady_run && $urandom_range(99) < 16) begin
			item_valid <= 1'b0;
			item       <= in_item_t'($urandom);
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= row.item;
		do @(posedge clk); while (!item_ready);
		predict_sgr_run(row.item);
		if (row.known) begin
			run_bytes.delete();
			for (int unsigned i = 0; i < row.count; i++) begin
				run_bytes.push_back(row.bytes[row.count - 1 - i]);
			end
		end
		foreach (run_bytes[i]) begin
			e.out_byte = run_bytes[i];
			e.last     = (i == run_bytes.size() - 1);
			sgr_expect_q.push_back(e);
		end
		@(negedge clk);
	endtask

	// Output side: random stalls except during the steady stretch
	initial begin
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ready <= arst_n && (steady_run || $urandom_range(99) >= 16);
		end
	end

	// Compare each output transaction with the oldest expected byte
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && res_valid && res_ready) begin
			rx_count++;
			if (sgr_expect_q.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %0b (output #%0d)",
					res.out_byte, res.last, rx_count));
			end else begin
				want = sgr_expect_q.pop_front();
				if (res.out_byte !== want.out_byte)
					report_mismatch($sformatf("output #%0d byte %02h, expected %02h",
						rx_count, res.out_byte, want.out_byte));
				if (res.last !== want.last)
					report_mismatch($sformatf("output #%0d last %0b, expected %0b",
						rx_count, res.last, want.last));
			end
		end
	end

	initial begin
		stim_row_t   row;
		int unsigned counted;
		int unsigned pick;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		steady_run = 1'b0;
		err_count  = 0;
		rx_count   = 0;
		req_attr   = ATTR_DEFAULT;
		shown_attr = ATTR_DEFAULT;
		shown_once = 1'b0;

		// First run sends every code, then unchanged attributes pass bytes alone
		add_row(mk_item(KIND_DATA, 3'd0, 3'd0, 1'b0, 1'b0, 8'h41), 1'b1,
			{CH_ESC, "[40;37;27;22mA"}, 15);
		add_row(mk_item(KIND_DATA, 3'd7, 3'd7, 1'b1, 1'b1, 8'h00), 1'b1, {8'h00}, 1);
		add_row(mk_item(KIND_RESTORE, 3'd7, 3'd7, 1'b1, 1'b1, 8'hFF), 1'b1, '0, 0);
		add_row(mk_item(KIND_UNUSED, 3'd7, 3'd7, 1'b1, 1'b1, 8'hFF), 1'b1, '0, 0);
		add_row(mk_item(KIND_SET, 3'd7, 3'd7, 1'b1, 1'b1, 8'hFF), 1'b1, '0, 0);
		add_row(mk_item(KIND_DATA, 3'd0, 3'd0, 1'b0, 1'b0, 8'hFF), 1'b1,
			{CH_ESC, "[47;7;1m", 8'hFF}, 10);
		add_row(mk_item(KIND_RESTORE, 3'd0, 3'd0, 1'b0, 1'b0, 8'h00), 1'b1,
			{CH_ESC, "[40;27;22m"}, 11);
		add_row(mk_item(KIND_RESTORE, 3'd0, 3'd0, 1'b0, 1'b0, 8'h00), 1'b1, '0, 0);
		// Back-to-back sets: only the later one matters
		add_row(mk_item(KIND_SET, 3'd0, 3'd0, 1'b0, 1'b0, 8'hAA), 1'b0, '0, 0);
		add_row(mk_item(KIND_SET, 3'd3, 3'd5, 1'b1, 1'b0, 8'h55), 1'b0, '0, 0);
		add_row(mk_item(KIND_DATA, 3'd1, 3'd6, 1'b0, 1'b1, 8'h80), 1'b0, '0, 0);
		add_row(mk_item(KIND_SET, 3'd3, 3'd5, 1'b1, 1'b0, 8'h00), 1'b0, '0, 0);
		add_row(mk_item(KIND_DATA, 3'd0, 3'd0, 1'b0, 1'b0, 8'h7F), 1'b0, '0, 0);
		// One code changes at a time
		add_row(mk_item(KIND_SET, 3'd3, 3'd2, 1'b1, 1'b0, 8'h00), 1'b0, '0, 0);
		add_row(mk_item(KIND_DATA, 3'd5, 3'd1, 1'b0, 1'b0, 8'h01), 1'b0, '0, 0);
		add_row(mk_item(KIND_SET, 3'd6, 3'd2, 1'b1, 1'b0, 8'h00), 1'b0, '0, 0);
		add_row(mk_item(KIND_DATA, 3'd2, 3'd4, 1'b1, 1'b1, 8'h02), 1'b0, '0, 0);
		add_row(mk_item(KIND_SET, 3'd6, 3'd2, 1'b0, 1'b0, 8'h00), 1'b0, '0, 0);
		add_row(mk_item(KIND_DATA, 3'd0, 3'd0, 1'b0, 1'b0, 8'h04), 1'b0, '0, 0);
		add_row(mk_item(KIND_SET, 3'd6, 3'd2, 1'b0, 1'b1, 8'h00), 1'b0, '0, 0);
		add_row(mk_item(KIND_DATA, 3'd0, 3'd0, 1'b0, 1'b0, 8'h08), 1'b0, '0, 0);
		add_row(mk_item(KIND_SET, 3'd6, 3'd2, 1'b0, 1'b0, 8'h00), 1'b0, '0, 0);
		add_row(mk_item(KIND_DATA, 3'd0, 3'd0, 1'b0, 1'b0, 8'h10), 1'b0, '0, 0);
		add_row(mk_item(KIND_SET, 3'd6, 3'd2, 1'b1, 1'b0, 8'h00), 1'b0, '0, 0);
		add_row(mk_item(KIND_DATA, 3'd0, 3'd0, 1'b0, 1'b0, 8'h20), 1'b0, '0, 0);

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_rows[k]) drive_row(stim_rows[k]);

		// Random text stream with attribute changes mixed in
		row.known = 1'b0;
		row.bytes = '0;
		row.count = 0;
		counted   = 0;
		while (counted < RANDOM_ITEMS) begin
			steady_run = (counted >= 120) && (counted < 200);
			row.item = in_item_t'($urandom);
			pick = $urandom_range(99);
			if (pick < 8) begin
				row.item.kind = KIND_UNUSED;
			end else if (pick < 33) begin
				row.item.kind = KIND_SET;
				// often keep or nudge the current attributes so small diffs show up
				if ($urandom_range(2) != 0) begin
					row.item.fg_color   = req_attr.fg;
					row.item.bg_color   = req_attr.bg;
					row.item.inverse_on = req_attr.inverse;
					row.item.bold_on    = req_attr.bold;
					case ($urandom_range(4))
						0: row.item.fg_color   = 3'($urandom);
						1: row.item.bg_color   = 3'($urandom);
						2: row.item.inverse_on = ~req_attr.inverse;
						3: row.item.bold_on    = ~req_attr.bold;
						default: ;
					endcase
				end
			end else if (pick < 88) begin
				row.item.kind = KIND_DATA;
			end else begin
				row.item.kind = KIND_RESTORE;
			end
			if (row.item.kind != KIND_UNUSED) counted++;
			drive_row(row);
		end
		steady_run = 1'b0;
		item_valid <= 1'b0;

		while (sgr_expect_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(2_000_000);
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/ace_pkg.sv
hdl/ace_front.sv
hdl/ace_queue.sv
hdl/ace_back.sv
hdl/ansi_color_escape_encoder.sv
verif/ansi_color_escape_encoder_tb.sv
